// File: rtl/core/osvl_pkg.sv
package osvl_pkg;

	// Defaults for the top-level parameters.
	localparam int CHANNELS_DEF     = 4;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Fixed field widths.
	localparam int CH_W  = 2;
	localparam int CUT_W = 17;
	localparam int RES_W = 16;

	// The integrators hold Q7.24 values.
	localparam int STATE_FRAC = 24;
	localparam int STATE_W    = 32;

	// Widths of the x powers (Q0.30), the shared multiplier and its product.
	localparam int XP_W  = 30;
	localparam int MA_W  = 35;
	localparam int MB_W  = 32;
	localparam int P_W   = MA_W + MB_W;
	localparam int ACC_W = 40;
	localparam int SUM_W = 34;

	// Coefficient constants in Q0.30, and the reciprocal of three in Q0.32.
	localparam logic [MB_W-1:0] CUT_SCALE = 32'd557758033;
	localparam logic [MB_W-1:0] INV6      = 32'd178956971;
	localparam logic [MB_W-1:0] INV120    = 32'd8947849;
	localparam logic [MB_W-1:0] INV5040   = 32'd213045;
	localparam logic [MB_W-1:0] RECIP3    = 32'd1431655765;

	localparam logic [CUT_W-1:0] ONE_Q16          = 17'd65536;
	localparam logic [CUT_W-1:0] MIN_CUTOFF_RESET = 17'd27;

	// Saturation limits of the integrators, seen in the accumulator width.
	localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh007FFFFFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 40'shFF80000000;

	// Filter passes per item.
	localparam int PASS_W = 2;
	localparam logic [PASS_W-1:0] LAST_PASS = 2'd2;

	// Micro-operations of the shared multiplier.
	typedef logic [3:0] op_t;
	localparam op_t OP_X   = 4'd0;
	localparam op_t OP_X2  = 4'd1;
	localparam op_t OP_X3  = 4'd2;
	localparam op_t OP_X5  = 4'd3;
	localparam op_t OP_X7  = 4'd4;
	localparam op_t OP_T3  = 4'd5;
	localparam op_t OP_T5  = 4'd6;
	localparam op_t OP_T7  = 4'd7;
	localparam op_t OP_FB  = 4'd8;
	localparam op_t OP_DB  = 4'd9;
	localparam op_t OP_FH  = 4'd10;
	localparam op_t OP_DIV = 4'd11;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul_en;
		logic wb_en;
		logic prep;
		logic fin;
		logic emit;
		op_t  op;
	} cmd_t;

	// Clamp an accumulator value to the signed 32-bit range.
	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > ACC_MAX) begin
			return 32'sh7FFFFFFF;
		end else if (v < ACC_MIN) begin
			return 32'sh80000000;
		end
		return v[STATE_W-1:0];
	endfunction

	// Channel number modulo the channel count.
	function automatic logic [CH_W+2:0] chan_wrap(input logic [CH_W-1:0] ch, input int n);
		int r;
		r = int'(ch);
		for (int i = 0; i < 3; i++) begin
			if (r >= n) begin
				r = r - n;
			end
		end
		return (CH_W + 3)'(r);
	endfunction

endpackage

// File: rtl/core/osvl_mul.sv
module osvl_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [osvl_pkg::MA_W-1:0]      a,
	input  logic signed [osvl_pkg::MB_W-1:0]      b,
	output logic signed [osvl_pkg::P_W-1:0]       p_q
);

	// Signed product, registered before anything uses it.
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// File: rtl/core/osvl_ctrl.sv
module osvl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output osvl_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_WB   = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                     state_q;
	osvl_pkg::op_t                  op_q;
	logic [osvl_pkg::PASS_W-1:0]    pass_q;
	logic                           out_valid_q;
	logic                           accept;
	logic                           emit_ok;

	// A new item enters only when the previous one has finished computing.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit_ok  = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd.load   = accept;
		cmd.mul_en = (state_q == ST_MUL);
		cmd.wb_en  = (state_q == ST_WB);
		cmd.prep   = (state_q == ST_PREP);
		cmd.fin    = (state_q == ST_FIN);
		cmd.emit   = emit_ok;
		cmd.op     = op_q;
	end

	// Sequencer: each operation is a multiply state followed by a write-back state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= osvl_pkg::OP_X;
			pass_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= osvl_pkg::OP_X;
						pass_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (op_q == osvl_pkg::OP_FH) begin
						if (pass_q == osvl_pkg::LAST_PASS) begin
							state_q <= ST_PREP;
						end else begin
							pass_q  <= pass_q + 1'b1;
							op_q    <= osvl_pkg::OP_FB;
							state_q <= ST_MUL;
						end
					end else if (op_q == osvl_pkg::OP_DIV) begin
						state_q <= ST_FIN;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_PREP: begin
					op_q    <= osvl_pkg::OP_DIV;
					state_q <= ST_MUL;
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/osvl_dp.sv
module osvl_dp #(
	parameter int CHANNELS     = osvl_pkg::CHANNELS_DEF,
	parameter int SAMPLE_WIDTH = osvl_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [osvl_pkg::CUT_W-1:0]         cfg_wr_data,
	input  logic [osvl_pkg::CH_W-1:0]          channel,
	input  logic [SAMPLE_WIDTH-1:0]            sample_in,
	input  logic [osvl_pkg::CUT_W-1:0]         cutoff,
	input  logic [osvl_pkg::RES_W-1:0]         resonance,
	input  osvl_pkg::cmd_t                     cmd,
	output logic [SAMPLE_WIDTH-1:0]            lowpass_out
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IN_SHIFT = osvl_pkg::STATE_FRAC - (SAMPLE_WIDTH - 1);
	localparam int XIN_W    = osvl_pkg::STATE_FRAC + 1;
	localparam int HP_W     = osvl_pkg::MA_W;
	localparam int ACC_W    = osvl_pkg::ACC_W;
	localparam int SUM_W    = osvl_pkg::SUM_W;
	localparam int STATE_W  = osvl_pkg::STATE_W;
	localparam int XP_W     = osvl_pkg::XP_W;
	localparam int MA_W     = osvl_pkg::MA_W;
	localparam int MB_W     = osvl_pkg::MB_W;
	localparam int P_W      = osvl_pkg::P_W;
	localparam int CUT_W    = osvl_pkg::CUT_W;
	localparam int R_W      = SUM_W + 2;

	localparam logic signed [P_W-1:0] HALF30   = P_W'(64'd536870912);
	localparam logic signed [P_W-1:0] HALF16   = P_W'(64'd32768);
	localparam logic [SUM_W-1:0]      HALF_DEN = SUM_W'((64'd3 << IN_SHIFT) >> 1);
	localparam logic [STATE_W-1:0]    MAXV     = STATE_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic [STATE_W-1:0]    MAXV_P1  = STATE_W'(64'd1 << (SAMPLE_WIDTH - 1));

	// Configuration and per-item operands.
	logic [CUT_W-1:0]                  min_cutoff_q;
	logic [CUT_W-1:0]                  c_q;
	logic [CUT_W-1:0]                  d_q;
	logic signed [XIN_W-1:0]           xin_q;
	logic [CH_IDX_W-1:0]               ch_q;

	// Coefficient terms.
	logic [XP_W-1:0]                   x_q;
	logic [XP_W-1:0]                   x2_q;
	logic [XP_W-1:0]                   x3_q;
	logic [XP_W-1:0]                   x5_q;
	logic [XP_W-1:0]                   x7_q;
	logic signed [STATE_W-1:0]         poly_q;

	// Filter state and output arithmetic.
	logic signed [STATE_W-1:0]         lp_q;
	logic signed [STATE_W-1:0]         bp_q;
	logic signed [HP_W-1:0]            hp_q;
	logic signed [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]                  v_q;
	logic                              neg_q;
	logic [STATE_W-1:0]                q_q;
	logic [SAMPLE_WIDTH-1:0]           out_q;

	logic signed [STATE_W-1:0]         lp_mem [CHANNELS];
	logic signed [STATE_W-1:0]         bp_mem [CHANNELS];

	logic [CUT_W-1:0]                  c_lo;
	logic [CUT_W-1:0]                  c_cl;
	logic [CH_IDX_W-1:0]               ch_idx;
	logic signed [STATE_W-1:0]         f;
	logic signed [MA_W-1:0]            mul_a;
	logic signed [MB_W-1:0]            mul_b;
	logic signed [P_W-1:0]             p;
	logic signed [P_W-1:0]             p_r30;
	logic signed [P_W-1:0]             p_r16;
	logic signed [ACC_W-1:0]           r30;
	logic signed [HP_W-1:0]            r16;
	logic signed [ACC_W-1:0]           lp_ext;
	logic signed [ACC_W-1:0]           bp_ext;
	logic [SUM_W-1:0]                  mag;
	logic [R_W-1:0]                    three_q;
	logic [R_W-1:0]                    rem;
	logic [SAMPLE_WIDTH-1:0]           res;

	// Lowest cutoff register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cutoff_q <= osvl_pkg::MIN_CUTOFF_RESET;
		end else if (cfg_wr_en) begin
			min_cutoff_q <= cfg_wr_data;
		end
	end

	// Cutoff clamp and channel selection at load time.
	assign c_lo   = (cutoff < min_cutoff_q) ? min_cutoff_q : cutoff;
	assign c_cl   = (c_lo > osvl_pkg::ONE_Q16) ? osvl_pkg::ONE_Q16 : c_lo;
	assign ch_idx = CH_IDX_W'(osvl_pkg::chan_wrap(channel, CHANNELS));

	// Frequency coefficient is twice the polynomial, Q0.30.
	assign f = {poly_q[STATE_W-2:0], 1'b0};

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			osvl_pkg::OP_X: begin
				mul_a = {{(MA_W-CUT_W){1'b0}}, c_q};
				mul_b = osvl_pkg::CUT_SCALE;
			end
			osvl_pkg::OP_X2: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x_q};
				mul_b = {{(MB_W-XP_W){1'b0}}, x_q};
			end
			osvl_pkg::OP_X3: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x2_q};
				mul_b = {{(MB_W-XP_W){1'b0}}, x_q};
			end
			osvl_pkg::OP_X5: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x3_q};
				mul_b = {{(MB_W-XP_W){1'b0}}, x2_q};
			end
			osvl_pkg::OP_X7: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x5_q};
				mul_b = {{(MB_W-XP_W){1'b0}}, x2_q};
			end
			osvl_pkg::OP_T3: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x3_q};
				mul_b = osvl_pkg::INV6;
			end
			osvl_pkg::OP_T5: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x5_q};
				mul_b = osvl_pkg::INV120;
			end
			osvl_pkg::OP_T7: begin
				mul_a = {{(MA_W-XP_W){1'b0}}, x7_q};
				mul_b = osvl_pkg::INV5040;
			end
			osvl_pkg::OP_FB: begin
				mul_a = {{(MA_W-STATE_W){f[STATE_W-1]}}, f};
				mul_b = bp_q;
			end
			osvl_pkg::OP_DB: begin
				mul_a = {{(MA_W-CUT_W){1'b0}}, d_q};
				mul_b = bp_q;
			end
			osvl_pkg::OP_FH: begin
				mul_a = hp_q;
				mul_b = f;
			end
			osvl_pkg::OP_DIV: begin
				mul_a = {{(MA_W-SUM_W){1'b0}}, v_q};
				mul_b = osvl_pkg::RECIP3;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	osvl_mul u_mul (
		.clk (clk),
		.en  (cmd.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p)
	);

	// Rounded views of the product, half up.
	assign p_r30  = (p + HALF30) >>> 30;
	assign p_r16  = (p + HALF16) >>> 16;
	assign r30    = p_r30[ACC_W-1:0];
	assign r16    = p_r16[HP_W-1:0];
	assign lp_ext = {{(ACC_W-STATE_W){lp_q[STATE_W-1]}}, lp_q};
	assign bp_ext = {{(ACC_W-STATE_W){bp_q[STATE_W-1]}}, bp_q};

	// Magnitude of the lowpass sum for the final division.
	assign mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// Remainder check for the quotient estimate, which is low by at most one.
	assign three_q = {{(R_W-STATE_W){1'b0}}, q_q} + {{(R_W-STATE_W-1){1'b0}}, q_q, 1'b0};
	assign rem     = {{(R_W-SUM_W){1'b0}}, v_q} - three_q;

	// Saturate the signed quotient to the sample range.
	always_comb begin
		if (neg_q) begin
			if (q_q > MAXV_P1) begin
				res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			end else begin
				res = SAMPLE_WIDTH'(-q_q[SAMPLE_WIDTH-1:0]);
			end
		end else if (q_q > MAXV) begin
			res = MAXV[SAMPLE_WIDTH-1:0];
		end else begin
			res = q_q[SAMPLE_WIDTH-1:0];
		end
	end

	// Working registers: load, write-back of each operation, and the final steps.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q   <= c_cl;
			d_q   <= osvl_pkg::ONE_Q16 - {1'b0, resonance};
			xin_q <= {sample_in, {IN_SHIFT{1'b0}}};
			ch_q  <= ch_idx;
			lp_q  <= lp_mem[ch_idx];
			bp_q  <= bp_mem[ch_idx];
			sum_q <= '0;
		end
		if (cmd.wb_en) begin
			case (cmd.op)
				osvl_pkg::OP_X:  x_q  <= p_r16[XP_W-1:0];
				osvl_pkg::OP_X2: x2_q <= r30[XP_W-1:0];
				osvl_pkg::OP_X3: x3_q <= r30[XP_W-1:0];
				osvl_pkg::OP_X5: x5_q <= r30[XP_W-1:0];
				osvl_pkg::OP_X7: x7_q <= r30[XP_W-1:0];
				osvl_pkg::OP_T3: poly_q <= $signed({2'b00, x_q}) - r30[STATE_W-1:0];
				osvl_pkg::OP_T5: poly_q <= poly_q + r30[STATE_W-1:0];
				osvl_pkg::OP_T7: poly_q <= poly_q - r30[STATE_W-1:0];
				osvl_pkg::OP_FB: lp_q <= osvl_pkg::sat32(lp_ext + r30);
				osvl_pkg::OP_DB: begin
					hp_q <= {{(HP_W-XIN_W){xin_q[XIN_W-1]}}, xin_q}
						- {{(HP_W-STATE_W){lp_q[STATE_W-1]}}, lp_q} - r16;
				end
				osvl_pkg::OP_FH: begin
					bp_q  <= osvl_pkg::sat32(r30 + bp_ext);
					sum_q <= sum_q + {{(SUM_W-STATE_W){lp_q[STATE_W-1]}}, lp_q};
				end
				osvl_pkg::OP_DIV: q_q <= p[2*STATE_W-1:STATE_W];
				default: begin
				end
			endcase
		end
		if (cmd.prep) begin
			v_q   <= (mag + HALF_DEN) >> IN_SHIFT;
			neg_q <= sum_q[SUM_W-1];
		end
		if (cmd.fin) begin
			if (rem >= R_W'(3)) begin
				q_q <= q_q + 1'b1;
			end
		end
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	// Per-channel integrators, written back when the item completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				lp_mem[i] <= '0;
				bp_mem[i] <= '0;
			end
		end else if (cmd.emit) begin
			lp_mem[ch_q] <= lp_q;
			bp_mem[ch_q] <= bp_q;
		end
	end

	assign lowpass_out = out_q;

endmodule

// File: rtl/core/oversampled_state_variable_lowpass_top.sv
// Channel   Dir  Signals                        Contents
// s_*       in   s_tvalid s_tready s_tdata      sample_in, cutoff, resonance
//                s_tuser                        channel
// m_*       out  m_tvalid m_tready m_tdata      lowpass_out
// cfg_*     in   cfg_wr_en cfg_wr_data          min_cutoff
//
// An item is processed one operation at a time on the single shared 35x32
// multiplier: 18 products (coefficient series, three filter passes, reciprocal
// divide by three), each a multiply step followed by a write-back step, plus
// load and finish steps. A new item is accepted only once the last is finished.
// Reset clears the channel integrators and sets min_cutoff to 27.
// The result waits in an output register; the next item is still accepted,
// and only the finish of that item waits for the register to be taken.
module oversampled_state_variable_lowpass_top #(
	parameter int CHANNELS     = osvl_pkg::CHANNELS_DEF,
	parameter int SAMPLE_WIDTH = osvl_pkg::SAMPLE_WIDTH_DEF,
	localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + osvl_pkg::CUT_W + osvl_pkg::RES_W + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [osvl_pkg::CUT_W-1:0]     cfg_wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [IN_TDATA_W-1:0]          s_tdata,   // sample_in, cutoff, resonance
	input  logic [osvl_pkg::CH_W-1:0]      s_tuser,   // channel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_TDATA_W-1:0]         m_tdata    // lowpass_out
);

	localparam int CUT_LO = SAMPLE_WIDTH;
	localparam int RES_LO = SAMPLE_WIDTH + osvl_pkg::CUT_W;

	osvl_pkg::cmd_t             cmd;
	logic [SAMPLE_WIDTH-1:0]    lowpass_out;

	osvl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	osvl_dp #(
		.CHANNELS     (CHANNELS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.channel     (s_tuser),
		.sample_in   (s_tdata[SAMPLE_WIDTH-1:0]),
		.cutoff      (s_tdata[CUT_LO +: osvl_pkg::CUT_W]),
		.resonance   (s_tdata[RES_LO +: osvl_pkg::RES_W]),
		.cmd         (cmd),
		.lowpass_out (lowpass_out)
	);

	assign m_tdata = OUT_TDATA_W'(lowpass_out);

endmodule
